// ----- rtl/core/idfce_pkg.sv -----
// Package for the ID frame checksum encoder.
// Holds sizing constants, frame byte codes, controller states and the
// command/status structs shared by the controller, datapath and top level.
package idfce_pkg;

  // Longest identifier kept in the character buffer (1 to 255)
  localparam int MAX_ID_LEN = 11;

  // Character count holds 0..MAX_ID_LEN
  localparam int CNT_W = $clog2(MAX_ID_LEN + 1);
  // Buffer index width, at least one bit
  localparam int IDX_W = (MAX_ID_LEN > 1) ? $clog2(MAX_ID_LEN) : 1;
  // Frame position: 4 header bytes, characters, 3 trailer bytes
  localparam int FRAME_MAX = MAX_ID_LEN + 7;
  localparam int POS_W = $clog2(FRAME_MAX);

  localparam int BYTE_W = 8;

  // Fixed frame bytes
  localparam logic [BYTE_W-1:0] FRAME_SYNC = 8'hA5;
  localparam logic [BYTE_W-1:0] FRAME_TAIL = 8'hD5;
  localparam logic [BYTE_W-1:0] FRAME_PAD  = 8'h00;

  // Frame positions of the header bytes
  localparam logic [POS_W-1:0] POS_SYNC = POS_W'(0);
  localparam logic [POS_W-1:0] POS_ZERO = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CHK  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LEN  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_DATA = POS_W'(4);

  // Controller states
  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;   // take the input word into the buffer
    logic step;   // load the next frame byte into the output register
    logic clear;  // return buffer state to empty
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic nonempty_nxt; // buffer holds a character once the input word is taken
    logic final_pos;    // current frame position is the closing byte
    logic slot_free;    // output register can take a byte this cycle
    logic count_nz;     // buffer holds at least one character
  } sts_t;

endpackage

// ----- rtl/core/idfce_ctrl.sv -----
// Controller for the ID frame checksum encoder.
// Two-state machine that sequences character loading and frame emission;
// depends on idfce_pkg.
module idfce_ctrl import idfce_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tlast,
  input  sts_t sts,
  output logic in_tready,
  output cmd_t cmd,
  output state_t state
);

  state_t state_r;
  state_t state_nxt;

  assign state = state_r;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_tvalid && in_tlast && sts.nonempty_nxt) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.slot_free && sts.final_pos) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
        // Empty identifier on the last word: drop it and start over
        cmd.clear = in_tvalid && in_tlast && !sts.nonempty_nxt;
      end
      ST_EMIT: begin
        cmd.step  = sts.slot_free;
        cmd.clear = sts.slot_free && sts.final_pos;
      end
      default: begin
        in_tready = 1'b0;
        cmd       = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/idfce_dp.sv -----
// Datapath for the ID frame checksum encoder.
// Character buffer, count, running sum, frame position and output register;
// depends on idfce_pkg.
module idfce_dp import idfce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] id_char
  input  logic              out_tready,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_tvalid,
  output logic [BYTE_W-1:0] out_tdata,  // [7:0] frame_byte
  output logic              out_tlast   // frame_last
);

  logic [BYTE_W-1:0] store_r [MAX_ID_LEN];
  logic [CNT_W-1:0]  count_r;
  logic              ended_r;
  logic [BYTE_W-1:0] sum_r;
  logic [POS_W-1:0]  pos_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_last_r;

  logic              char_ok;
  logic [BYTE_W-1:0] len_byte;
  logic [BYTE_W-1:0] chk_byte;
  logic [POS_W-1:0]  count_pos;
  logic [POS_W-1:0]  data_off;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  wr_idx;
  logic [BYTE_W-1:0] byte_nxt;

  // A character is taken while no end mark was seen and the buffer has room
  assign char_ok = !ended_r && (count_r < CNT_W'(MAX_ID_LEN));

  assign len_byte  = BYTE_W'(count_r);
  assign chk_byte  = BYTE_W'(9'h100 - {1'b0, BYTE_W'(sum_r + len_byte + FRAME_TAIL)});
  assign count_pos = POS_W'(count_r);
  assign data_off  = pos_r - POS_DATA;
  assign rd_idx    = data_off[IDX_W-1:0];
  assign wr_idx    = count_r[IDX_W-1:0];

  // Status to controller
  assign sts.nonempty_nxt = (count_r != '0) || (char_ok && (in_tdata != '0));
  assign sts.final_pos    = (pos_r == count_pos + POS_W'(6));
  assign sts.slot_free    = !out_valid_r || out_tready;
  assign sts.count_nz     = (count_r != '0);

  // Select the byte at the current frame position
  always_comb begin
    priority if (pos_r == POS_SYNC) begin
      byte_nxt = FRAME_SYNC;
    end else if (pos_r == POS_ZERO) begin
      byte_nxt = FRAME_PAD;
    end else if (pos_r == POS_CHK) begin
      byte_nxt = chk_byte;
    end else if (pos_r == POS_LEN) begin
      byte_nxt = len_byte;
    end else if (pos_r < count_pos + POS_DATA) begin
      byte_nxt = store_r[rd_idx];
    end else if (pos_r == count_pos + POS_W'(5)) begin
      byte_nxt = FRAME_TAIL;
    end else begin
      byte_nxt = FRAME_PAD;
    end
  end

  // Write characters into the buffer
  always_ff @(posedge clk) begin
    if (cmd.take && char_ok && (in_tdata != '0)) begin
      store_r[wr_idx] <= in_tdata;
    end
  end

  // Count, end mark, running sum and frame position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ended_r <= 1'b0;
      sum_r   <= '0;
      pos_r   <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
      ended_r <= 1'b0;
      sum_r   <= '0;
      pos_r   <= '0;
    end else begin
      if (cmd.take && char_ok) begin
        if (in_tdata == '0) begin
          ended_r <= 1'b1;
        end else begin
          count_r <= count_r + CNT_W'(1);
          sum_r   <= sum_r + in_tdata;
        end
      end
      if (cmd.step) begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  // Output register: load on step, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_data_r <= byte_nxt;
      out_last_r <= sts.final_pos;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/core/id_frame_checksum_encoder.sv -----
// ID frame checksum encoder, top level. Depends on idfce_pkg, idfce_ctrl, idfce_dp.
// Throughput: one character word per cycle while loading; the last word then
// starts a frame of count+7 bytes sent at one byte per cycle by the output register
// while out_tready is high. The last word moves the controller to ST_EMIT, which then
// loads frame bytes; no input word is taken until the closing byte is loaded there.
// Reset (rst_n low, synchronous) empties the buffer and output register.
module id_frame_checksum_encoder import idfce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] id_char
  input  logic              in_tlast,   // last
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,  // [7:0] frame_byte
  output logic              out_tlast   // frame_last
);

  cmd_t   cmd;
  sts_t   sts;
  state_t state;

  idfce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd),
    .state     (state)
  );

  idfce_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A frame is only emitted for a nonempty identifier
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_EMIT) |-> sts.count_nz)
    else $error("emitting a frame with an empty buffer");

  // A last word with a character in hand starts a frame
  a_last_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast && sts.nonempty_nxt) |=> (state == ST_EMIT))
    else $error("last word did not start a frame");

  // The closing byte of a frame is always the zero pad
  a_close_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata == FRAME_PAD))
    else $error("frame closing byte is not zero");

  // Step and new input never coincide
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && cmd.take))
    else $error("frame step overlaps input take");

endmodule
